// ----- src/mbps_pkg.sv -----
`timescale 1ns / 1ps

package mbps_pkg;

  localparam int MaxPattern = 32;
  localparam int IdxW       = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int CntW       = $clog2(MaxPattern + 1);
  localparam int NumWords   = 4;
  localparam int WordW      = 64;
  localparam int MaskW      = 32;
  localparam int LenW       = 6;
  localparam int AddrW      = 48;
  localparam int ByteW      = 8;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;

  localparam logic [CfgIdxW-1:0] CfgPattern0 = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgPattern1 = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgPattern2 = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgPattern3 = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] CfgMask     = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] CfgLength   = CfgIdxW'(5);

  typedef struct packed {
    logic [NumWords-1:0][WordW-1:0] pattern;
    logic [MaskW-1:0]               mask;
    logic [LenW-1:0]                length;
  } cfg_t;

  // positions past the four pattern words read as zero
  function automatic logic [ByteW-1:0] pattern_byte(input cfg_t cfg, input int j);
    logic [ByteW-1:0] b;
    b = '0;
    if (j < NumWords * 8) begin
      b = cfg.pattern[j / 8][(j % 8) * 8 +: 8];
    end
    return b;
  endfunction

  function automatic logic is_wildcard(input cfg_t cfg, input int j);
    logic w;
    w = 1'b0;
    if (j < MaskW) begin
      w = cfg.mask[j];
    end
    return w;
  endfunction

endpackage

// ----- src/mbps_in_if.sv -----
`timescale 1ns / 1ps

interface mbps_in_if;
  logic                      valid;
  logic                      ready;
  logic [mbps_pkg::ByteW-1:0] data_byte;
  logic [mbps_pkg::AddrW-1:0] byte_address;
  logic                      region_start;

  modport source (output valid, data_byte, byte_address, region_start, input ready);
  modport sink   (input valid, data_byte, byte_address, region_start, output ready);
endinterface

// ----- src/mbps_out_if.sv -----
`timescale 1ns / 1ps

interface mbps_out_if;
  logic                      valid;
  logic                      ready;
  logic [mbps_pkg::AddrW-1:0] match_address;

  modport source (output valid, match_address, input ready);
  modport sink   (input valid, match_address, output ready);
endinterface

// ----- src/mbps_cfg_if.sv -----
`timescale 1ns / 1ps

interface mbps_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mbps_pkg::CfgIdxW-1:0] index;
  logic [mbps_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/mbps_cfg_regs.sv -----
`timescale 1ns / 1ps

module mbps_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  mbps_cfg_if.sink       cfg_i,
  output mbps_pkg::cfg_t cfg_o
);

  mbps_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        mbps_pkg::CfgPattern0: cfg_d.pattern[0] = cfg_i.data;
        mbps_pkg::CfgPattern1: cfg_d.pattern[1] = cfg_i.data;
        mbps_pkg::CfgPattern2: cfg_d.pattern[2] = cfg_i.data;
        mbps_pkg::CfgPattern3: cfg_d.pattern[3] = cfg_i.data;
        mbps_pkg::CfgMask:     cfg_d.mask       = cfg_i.data[mbps_pkg::MaskW-1:0];
        mbps_pkg::CfgLength:   cfg_d.length     = cfg_i.data[mbps_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern <= '0;
      cfg_q.mask    <= '0;
      cfg_q.length  <= mbps_pkg::LenW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- src/mbps_window.sv -----
`timescale 1ns / 1ps

module mbps_window (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mbps_pkg::cfg_t             cfg_i,
  input  logic                       step_i,
  input  logic [mbps_pkg::ByteW-1:0] data_byte_i,
  input  logic [mbps_pkg::AddrW-1:0] byte_address_i,
  input  logic                       region_start_i,
  output logic                       hit_o,
  output logic [mbps_pkg::AddrW-1:0] match_address_o
);

  logic [mbps_pkg::ByteW-1:0] wnd_q [mbps_pkg::MaxPattern];
  logic [mbps_pkg::ByteW-1:0] wnd_d [mbps_pkg::MaxPattern];
  logic [mbps_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [mbps_pkg::CntW-1:0]  cnt_base;
  logic                       len_ok;
  logic                       mism;

  always_comb begin
    wnd_d[0] = data_byte_i;
    for (int i = 1; i < mbps_pkg::MaxPattern; i++) begin
      wnd_d[i] = wnd_q[i-1];
    end
  end

  always_comb begin
    cnt_base = region_start_i ? '0 : cnt_q;
    cnt_d    = cnt_base;
    if (int'(cnt_base) < mbps_pkg::MaxPattern) begin
      cnt_d = cnt_base + mbps_pkg::CntW'(1);
    end
  end

  // pattern byte j lines up with the byte taken (length - 1 - j) items ago
  always_comb begin
    int sel;
    mism = 1'b0;
    for (int j = 0; j < mbps_pkg::MaxPattern; j++) begin
      sel = int'(cfg_i.length) - 1 - j;
      if (j < int'(cfg_i.length) && !mbps_pkg::is_wildcard(cfg_i, j)) begin
        if (wnd_d[sel[mbps_pkg::IdxW-1:0]] != mbps_pkg::pattern_byte(cfg_i, j)) begin
          mism = 1'b1;
        end
      end
    end
  end

  assign len_ok = (cfg_i.length != '0) && (int'(cfg_i.length) <= mbps_pkg::MaxPattern);
  assign hit_o  = len_ok && (int'(cnt_d) >= int'(cfg_i.length)) && !mism;
  assign match_address_o = byte_address_i - mbps_pkg::AddrW'(cfg_i.length - mbps_pkg::LenW'(1));

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      wnd_q <= wnd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= mbps_pkg::MaxPattern)
    else $error("valid count above maximum");

  a_cnt_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && region_start_i |=> cnt_q == mbps_pkg::CntW'(1))
    else $error("region start did not restart count");
`endif

endmodule

// ----- src/masked_byte_pattern_scanner_top.sv -----
`timescale 1ns / 1ps

// Masked byte pattern scanner.
// in_i  : one item per byte: data_byte, byte_address, region_start (valid/ready).
//         region_start restarts the run, so no match spans two regions.
// out_o : one item per match: match_address, address of the oldest byte of
//         the matching window, modulo 2^48.
// cfg_i : register writes (index, data), always ready; write only while idle.
//         0..3 pattern words, 4 wildcard mask, 5 length (1..32, else no match).
// Path: input register, then result register; a match shows as out_o.valid.
// Throughput: one item per cycle unless out_o stalls; the window compare is
// one pass over 32 byte comparators between the input and result registers.
// Stall: with a result held and out_o.ready low, one more item is taken into
// the input register, then in_i.ready drops until the result is taken.
// Reset: pattern words and mask clear, length returns to 1, run count clears,
// both stages empty.
module masked_byte_pattern_scanner_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  mbps_cfg_if.sink   cfg_i,
  mbps_in_if.sink    in_i,
  mbps_out_if.source out_o
);

  mbps_pkg::cfg_t             cfg;
  logic                       a_valid_q;
  logic [mbps_pkg::ByteW-1:0] a_byte_q;
  logic [mbps_pkg::AddrW-1:0] a_addr_q;
  logic                       a_start_q;
  logic                       adv;
  logic                       step;
  logic                       hit;
  logic [mbps_pkg::AddrW-1:0] match_addr;
  logic                       out_valid_q;
  logic [mbps_pkg::AddrW-1:0] out_addr_q;

  mbps_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign adv        = !out_valid_q || out_o.ready;
  assign step       = a_valid_q && adv;
  assign in_i.ready = !a_valid_q || adv;

  mbps_window u_window (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .step_i          (step),
    .data_byte_i     (a_byte_q),
    .byte_address_i  (a_addr_q),
    .region_start_i  (a_start_q),
    .hit_o           (hit),
    .match_address_o (match_addr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      a_valid_q <= 1'b1;
    end else if (adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      a_byte_q  <= in_i.data_byte;
      a_addr_q  <= in_i.byte_address;
      a_start_q <= in_i.region_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= hit;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && hit) begin
      out_addr_q <= match_addr;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.match_address = out_addr_q;

`ifndef SYNTHESIS
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> a_valid_q && out_valid_q && !out_o.ready)
    else $error("input stalled without a full pipeline");

  a_hit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && hit |=> out_valid_q && out_addr_q == $past(match_addr))
    else $error("match not presented");

  a_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !hit |=> !out_valid_q)
    else $error("result without match");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import mbps_pkg::*;

  localparam int ItemTarget  = 1650;
  localparam int CycleLimit  = 300000;
  localparam int HoldCycles  = 300;
  localparam int DrainLimit  = 2000;
  localparam int DrainCycles = 8;

  localparam logic [CfgIdxW-1:0] CfgSpare0 = CfgIdxW'(6);
  localparam logic [CfgIdxW-1:0] CfgSpare1 = CfgIdxW'(7);

  typedef struct {
    logic [ByteW-1:0] data;
    logic [AddrW-1:0] addr;
    logic             start;
  } scan_item_t;

  typedef enum logic [1:0] {RxFree, RxCoin, RxSparse, RxPeriodic} rx_mode_e;

  logic clk_i;
  logic rst_ni;

  mbps_cfg_if cfg_bus ();
  mbps_in_if  byte_bus ();
  mbps_out_if match_bus ();

  masked_byte_pattern_scanner_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .in_i  (byte_bus),
    .out_o (match_bus)
  );

  cfg_t             scan_cfg;
  logic [ByteW-1:0] hist [MaxPattern];
  int               run_len;
  logic [AddrW-1:0] match_q [$];
  scan_item_t       pending [$];
  logic [AddrW-1:0] gen_addr;
  int               item_total;
  int               err_cnt;
  int               hold_reqs;
  bit               in_acc;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic logic [ByteW-1:0] pat_at(input int j);
    return scan_cfg.pattern[j / 8][(j % 8) * 8 +: 8];
  endfunction

  // shift the byte into the window and look for a full masked match
  task automatic scan_step(input logic [ByteW-1:0] b, input logic [AddrW-1:0] a,
                           input logic s);
    int len;
    bit hit;
    len = scan_cfg.length;
    if (s) run_len = 0;
    for (int i = MaxPattern - 1; i > 0; i--) hist[i] = hist[i - 1];
    hist[0] = b;
    if (run_len < MaxPattern) run_len++;
    if (len == 0 || len > MaxPattern || run_len < len) return;
    hit = 1'b1;
    for (int j = 0; j < len; j++) begin
      if (!scan_cfg.mask[j] && hist[len - 1 - j] != pat_at(j)) hit = 1'b0;
    end
    if (hit) match_q.insert(match_q.size(), a - AddrW'(len - 1));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && byte_bus.valid && byte_bus.ready) begin
      scan_step(byte_bus.data_byte, byte_bus.byte_address, byte_bus.region_start);
    end
    in_acc <= rst_ni && byte_bus.valid && byte_bus.ready;
  end

  always @(posedge clk_i) begin : check_matches
    logic [AddrW-1:0] want;
    if (rst_ni && match_bus.valid && match_bus.ready) begin
      if (match_q.size() == 0) begin
        report_mismatch($sformatf("unexpected match at %h", match_bus.match_address));
      end else begin
        want = match_q.pop_front();
        if (match_bus.match_address !== want) begin
          report_mismatch($sformatf("match_address %h, want %h",
                                    match_bus.match_address, want));
        end
      end
    end
  end

  // byte sender: bursts with random gaps, valid held until taken
  always @(negedge clk_i) begin : byte_sender
    int burst_left;
    int gap_left;
    if (rst_ni) begin
      if (in_acc) begin
        pending.delete(0);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 15) == 0) gap_left = 15;
          else if ($urandom_range(0, 2) == 0) gap_left = 0;
          else gap_left = $urandom_range(1, 6);
        end
      end
      if (!(byte_bus.valid && !in_acc)) begin
        if (gap_left > 0) begin
          gap_left--;
          byte_bus.valid <= 1'b0;
        end else if (pending.size() > 0) begin
          byte_bus.valid        <= 1'b1;
          byte_bus.data_byte    <= pending[0].data;
          byte_bus.byte_address <= pending[0].addr;
          byte_bus.region_start <= pending[0].start;
        end else begin
          byte_bus.valid <= 1'b0;
        end
      end
    end
  end

  // match receiver: switches between random stall patterns
  always @(negedge clk_i) begin : match_receiver
    int       holds_done;
    int       hold_left;
    int       mode_left;
    int       tick;
    rx_mode_e rx_mode;
    if (rst_ni) begin
      tick++;
      if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        hold_left  = HoldCycles;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        match_bus.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RxFree:     match_bus.ready <= 1'b1;
          RxCoin:     match_bus.ready <= 1'($urandom_range(0, 1));
          RxSparse:   match_bus.ready <= ($urandom_range(0, 7) != 0);
          RxPeriodic: match_bus.ready <= (tick % 4 != 3);
          default:    match_bus.ready <= 1'b1;
        endcase
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      CfgPattern0, CfgPattern1, CfgPattern2, CfgPattern3: scan_cfg.pattern[idx[1:0]] = val;
      CfgMask:   scan_cfg.mask   = val[MaskW-1:0];
      CfgLength: scan_cfg.length = val[LenW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic push_at(input logic [ByteW-1:0] b, input logic [AddrW-1:0] a,
                         input logic s);
    scan_item_t it;
    it.data  = b;
    it.addr  = a;
    it.start = s;
    pending.insert(pending.size(), it);
    item_total++;
  endtask

  task automatic push_next(input logic [ByteW-1:0] b, input logic s);
    push_at(b, gen_addr, s);
    gen_addr = gen_addr + AddrW'(1);
  endtask

  function automatic logic [ByteW-1:0] noise_byte();
    int len = scan_cfg.length;
    if (len >= 1 && len <= MaxPattern && $urandom_range(0, 1) == 1) begin
      return pat_at($urandom_range(0, len - 1));
    end
    return ByteW'($urandom);
  endfunction

  // one contiguous address run: noise runs and pattern copies, some of them broken; region starts may fall inside it
  task automatic gen_region();
    int               len;
    int               k;
    int               brk;
    bit               first;
    logic [ByteW-1:0] copy [MaxPattern];
    len = scan_cfg.length;
    case ($urandom_range(0, 7))
      0:       gen_addr = AddrW'($urandom_range(0, 40));
      1:       gen_addr = '1 - AddrW'($urandom_range(0, 40));
      default: gen_addr = AddrW'({$urandom, $urandom});
    endcase
    first = 1'b1;
    repeat ($urandom_range(1, 6)) begin
      if (len == 0 || len > MaxPattern || $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          push_next(noise_byte(), first || ($urandom_range(0, 39) == 0));
          first = 1'b0;
        end
      end else begin
        for (k = 0; k < len; k++) begin
          copy[k] = scan_cfg.mask[k] ? ByteW'($urandom) : pat_at(k);
        end
        if ($urandom_range(0, 5) == 0) begin
          k = $urandom_range(0, len - 1);
          copy[k] ^= ByteW'($urandom_range(1, 255));
        end
        brk = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len) : 0;
        for (k = 0; k < len; k++) begin
          push_next(copy[k], first || (k != 0 && k == brk));
          first = 1'b0;
        end
      end
    end
  endtask

  task automatic set_phase(input int p);
    logic [WordW-1:0]    w [NumWords];
    logic [MaskW-1:0]    m;
    logic [CfgDataW-1:0] l;
    for (int i = 0; i < NumWords; i++) w[i] = {$urandom, $urandom};
    m = $urandom;
    l = {$urandom, $urandom};
    case (p)
      0: begin
        m = '0;
        l[LenW-1:0] = LenW'(MaxPattern);
      end
      1: begin
        m = '1;
        l[LenW-1:0] = LenW'(1);
      end
      2: begin
        for (int i = 0; i < NumWords; i++) w[i] = '1;
        m = '1;
        l[LenW-1:0] = LenW'(MaxPattern);
      end
      3: begin
        for (int i = 0; i < NumWords; i++) w[i] = '0;
        m = '0;
        l[LenW-1:0] = LenW'(2);
      end
      default: begin
        case ($urandom_range(0, 9))
          0:       l[LenW-1:0] = '0;
          1:       l[LenW-1:0] = LenW'($urandom_range(MaxPattern + 1, 63));
          2:       l[LenW-1:0] = LenW'(MaxPattern);
          3, 4, 5: l[LenW-1:0] = LenW'($urandom_range(1, 3));
          default: l[LenW-1:0] = LenW'($urandom_range(1, MaxPattern));
        endcase
        case ($urandom_range(0, 3))
          0:       m = '0;
          1:       m = '1;
          2:       m = $urandom & $urandom & $urandom;
          default: ;
        endcase
        if ($urandom_range(0, 5) == 0) w[$urandom_range(0, NumWords - 1)] = '0;
      end
    endcase
    write_reg(CfgPattern0, w[0]);
    write_reg(CfgPattern1, w[1]);
    write_reg(CfgPattern2, w[2]);
    write_reg(CfgPattern3, w[3]);
    write_reg(CfgMask, {32'($urandom), m});
    write_reg(CfgLength, l);
    if ($urandom_range(0, 3) == 0) write_reg(CfgSpare0, {$urandom, $urandom});
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    do @(negedge clk_i); while (pending.size() != 0 || byte_bus.valid);
    while (match_q.size() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(negedge clk_i);
    if (match_q.size() != 0) begin
      report_mismatch($sformatf("%0d matches never arrived", match_q.size()));
      match_q.delete();
    end
  endtask

  initial begin : stimulus
    int phase;
    int budget;
    rst_ni                = 1'b0;
    byte_bus.valid        = 1'b0;
    byte_bus.data_byte    = '0;
    byte_bus.byte_address = '0;
    byte_bus.region_start = 1'b0;
    match_bus.ready       = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = '0;
    cfg_bus.data          = '0;
    scan_cfg              = '0;
    scan_cfg.length       = LenW'(1);
    for (int i = 0; i < MaxPattern; i++) hist[i] = '0;
    run_len = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: one-byte pattern of zero
    push_at(8'h00, '0, 1'b1);
    push_at(8'hFF, '1, 1'b0);
    push_at(8'h00, '1, 1'b0);
    push_at(8'h80, AddrW'(1), 1'b0);
    push_at(8'h00, {24{2'b10}}, 1'b1);
    push_at(8'h00, {24{2'b01}}, 1'b0);
    wait_idle();

    // spare indexes change nothing
    write_reg(CfgSpare0, '1);
    write_reg(CfgSpare1, {$urandom, $urandom});
    push_at(8'h00, AddrW'(48'h123), 1'b0);
    wait_idle();

    // zero and oversized lengths never match
    write_reg(CfgLength, '0);
    repeat (3) push_at(8'h00, AddrW'($urandom), 1'b0);
    wait_idle();
    write_reg(CfgLength, '1);
    repeat (2) push_at(8'h00, AddrW'($urandom), 1'b0);
    wait_idle();
    write_reg(CfgLength, CfgDataW'(MaxPattern + 1));
    push_at(8'h00, AddrW'($urandom), 1'b0);
    wait_idle();

    // A5 ?? C3: short region, then a match wrapping below address zero
    write_reg(CfgPattern0, 64'h0000_0000_00C3_5AA5);
    write_reg(CfgMask, 64'h2);
    write_reg(CfgLength, 64'd3);
    push_at(8'hA5, AddrW'(100), 1'b1);
    push_at(8'h5A, AddrW'(101), 1'b0);
    push_at(8'hC3, AddrW'(102), 1'b1);
    push_at(8'hA5, '1, 1'b1);
    push_at(8'h77, '0, 1'b0);
    push_at(8'hC3, AddrW'(1), 1'b0);
    wait_idle();

    phase = 0;
    while (item_total < ItemTarget) begin
      set_phase(phase);
      if (phase == 1) hold_reqs++;
      budget = item_total + $urandom_range(60, 160);
      while (item_total < budget) gen_region();
      wait_idle();
      phase++;
    end

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
